[sv/hrv_pkg.sv]
// Package with the codes and character tables of the HTTP request validator.
`timescale 1ns / 1ps

package hrv_pkg;

    typedef enum logic [2:0] {
        V_ACCEPTED        = 3'd0,
        V_BAD_REQUEST     = 3'd1,
        V_NOT_ALLOWED     = 3'd2,
        V_NOT_IMPLEMENTED = 3'd3,
        V_BAD_VERSION     = 3'd4,
        V_TOO_LARGE       = 3'd5
    } verdict_t;

    typedef enum logic [3:0] {
        M_UNKNOWN = 4'd0,
        M_GET     = 4'd1,
        M_HEAD    = 4'd2,
        M_POST    = 4'd3,
        M_PUT     = 4'd4,
        M_OPTIONS = 4'd5,
        M_DELETE  = 4'd6,
        M_TRACE   = 4'd7,
        M_CONNECT = 4'd8
    } method_t;

    typedef enum logic [3:0] {
        VP_LIT0  = 4'd0,
        VP_LIT1  = 4'd1,
        VP_LIT2  = 4'd2,
        VP_LIT3  = 4'd3,
        VP_SLASH = 4'd4,
        VP_MAJ0  = 4'd5,
        VP_MAJ   = 4'd6,
        VP_MIN0  = 4'd7,
        VP_MIN   = 4'd8,
        VP_FAIL  = 4'd9
    } vphase_t;

    localparam logic [2:0] TOK_METHOD  = 3'd1;
    localparam logic [2:0] TOK_URI     = 3'd2;
    localparam logic [2:0] TOK_VERSION = 3'd3;
    localparam logic [2:0] TOK_SAT     = 3'd4;

    localparam logic [1:0] CRLF_SAT  = 2'd3;
    localparam logic [3:0] MPOS_SAT  = 4'd15;
    localparam logic [3:0] VPOS_SAT  = 4'd9;
    localparam logic [3:0] VPOS_FULL = 4'd8;
    localparam logic [2:0] HOST_LAST = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_H     = "H";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";

    localparam logic [15:0] LIMIT_RESET = 16'd8192;

    localparam logic [7:0] HOST_LIT [5] = '{"H", "o", "s", "t", ":"};
    localparam logic [7:0] VER_LIT  [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};

    localparam logic [3:0] METH_LEN [8] = '{4'd3, 4'd4, 4'd4, 4'd3, 4'd7, 4'd6, 4'd5, 4'd7};

    localparam logic [7:0] METH_CHARS [8][8] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
        '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T", 8'h00}
    };

endpackage

[sv/http_request_validator.sv]
// HTTP/1.1 request line and Host header validator, one byte per cycle when not stalled.
`timescale 1ns / 1ps

// Takes one request byte per item on the s_ side and gives one verdict item on
// the m_ side for the byte marked by s_tlast. A byte is taken every cycle
// unless the input stalls; a byte passes an input register and then one
// combinational parse step into the state and result registers. Only a verdict
// that is still held on the m_ side stalls the input, and then only when the
// next byte to be parsed is itself a last byte. A write on the cfg_ port
// changes the size limit at once.
module http_request_validator #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // max_request_bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tlast,       // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // [2:0] verdict, [6:3] method_code,
                                       // [22:7] uri_offset, [38:23] uri_length
);

    localparam int EXT_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef struct packed {
        logic [COUNT_BITS-1:0] byte_count;
        logic [1:0]            crlf_count;
        logic                  prev_cr;
        logic [2:0]            token_index;
        logic                  in_token;
        logic [7:0]            cand;
        logic [3:0]            mpos;
        hrv_pkg::vphase_t      vphase;
        logic [3:0]            vpos;
        logic                  vexact;
        logic [COUNT_BITS-1:0] uri_start;
        logic [COUNT_BITS-1:0] uri_len;
        logic [2:0]            hpos;
        logic                  line_host;
        logic                  prev_line_host;
        logic                  host_ok;
        logic                  terminated;
    } parse_t;

    function automatic parse_t clear_state();
        parse_t s;
        s                = '0;
        s.cand           = 8'hFF;
        s.vphase         = hrv_pkg::VP_LIT0;
        s.vexact         = 1'b1;
        return s;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= hrv_pkg::CH_ZERO) && (c <= hrv_pkg::CH_NINE);
    endfunction

    function automatic parse_t method_char(input parse_t s_in, input logic [7:0] c);
        parse_t s;
        s = s_in;
        for (int i = 0; i < 8; i++) begin
            if (s.mpos >= hrv_pkg::METH_LEN[i] ||
                hrv_pkg::METH_CHARS[i][s.mpos[2:0]] != c) begin
                s.cand[i] = 1'b0;
            end
        end
        if (s.mpos != hrv_pkg::MPOS_SAT) begin
            s.mpos = s.mpos + 4'd1;
        end
        return s;
    endfunction

    function automatic parse_t version_char(input parse_t s_in, input logic [7:0] c);
        parse_t s;
        s = s_in;
        unique case (s.vphase)
            hrv_pkg::VP_LIT0:
                s.vphase = (c == hrv_pkg::VER_LIT[0]) ? hrv_pkg::VP_LIT1 : hrv_pkg::VP_FAIL;
            hrv_pkg::VP_LIT1:
                s.vphase = (c == hrv_pkg::VER_LIT[1]) ? hrv_pkg::VP_LIT2 : hrv_pkg::VP_FAIL;
            hrv_pkg::VP_LIT2:
                s.vphase = (c == hrv_pkg::VER_LIT[2]) ? hrv_pkg::VP_LIT3 : hrv_pkg::VP_FAIL;
            hrv_pkg::VP_LIT3:
                s.vphase = (c == hrv_pkg::VER_LIT[3]) ? hrv_pkg::VP_SLASH : hrv_pkg::VP_FAIL;
            hrv_pkg::VP_SLASH:
                s.vphase = (c == hrv_pkg::CH_SLASH) ? hrv_pkg::VP_MAJ0 : hrv_pkg::VP_FAIL;
            hrv_pkg::VP_MAJ0:
                s.vphase = is_digit(c) ? hrv_pkg::VP_MAJ : hrv_pkg::VP_FAIL;
            hrv_pkg::VP_MAJ:
                s.vphase = is_digit(c) ? hrv_pkg::VP_MAJ :
                           (c == hrv_pkg::CH_DOT) ? hrv_pkg::VP_MIN0 : hrv_pkg::VP_FAIL;
            hrv_pkg::VP_MIN0, hrv_pkg::VP_MIN:
                s.vphase = is_digit(c) ? hrv_pkg::VP_MIN : hrv_pkg::VP_FAIL;
            default:
                s.vphase = hrv_pkg::VP_FAIL;
        endcase
        if (s.vpos >= hrv_pkg::VPOS_FULL || c != hrv_pkg::VER_LIT[s.vpos[2:0]]) begin
            s.vexact = 1'b0;
        end
        if (s.vpos != hrv_pkg::VPOS_SAT) begin
            s.vpos = s.vpos + 4'd1;
        end
        return s;
    endfunction

    function automatic parse_t line_char(input parse_t s_in, input logic [7:0] c,
                                         input logic [COUNT_BITS-1:0] pos);
        parse_t s;
        s = s_in;
        if (c == hrv_pkg::HOST_LIT[s.hpos]) begin
            if (s.hpos == hrv_pkg::HOST_LAST) begin
                s.line_host = 1'b1;
                s.hpos      = 3'd0;
            end
            else begin
                s.hpos = s.hpos + 3'd1;
            end
        end
        else begin
            s.hpos = (c == hrv_pkg::CH_H) ? 3'd1 : 3'd0;
        end
        if (s.crlf_count == 2'd0) begin
            if (c == hrv_pkg::CH_SP) begin
                s.in_token = 1'b0;
            end
            else begin
                if (!s.in_token) begin
                    s.in_token = 1'b1;
                    if (s.token_index < hrv_pkg::TOK_SAT) begin
                        s.token_index = s.token_index + 3'd1;
                    end
                    if (s.token_index == hrv_pkg::TOK_URI) begin
                        s.uri_start = pos;
                    end
                end
                priority if (s.token_index == hrv_pkg::TOK_METHOD) begin
                    s = method_char(s, c);
                end
                else if (s.token_index == hrv_pkg::TOK_URI) begin
                    if (s.uri_len != '1) begin
                        s.uri_len = s.uri_len + COUNT_BITS'(1);
                    end
                end
                else if (s.token_index == hrv_pkg::TOK_VERSION) begin
                    s = version_char(s, c);
                end
                else begin
                    s = s;
                end
            end
        end
        return s;
    endfunction

    function automatic parse_t line_end(input parse_t s_in);
        parse_t s;
        s = s_in;
        if (s.prev_line_host) begin
            s.host_ok = 1'b1;
        end
        s.prev_line_host = (s.crlf_count != 2'd0) && s.line_host;
        s.line_host      = 1'b0;
        s.hpos           = 3'd0;
        if (s.crlf_count != hrv_pkg::CRLF_SAT) begin
            s.crlf_count = s.crlf_count + 2'd1;
        end
        return s;
    endfunction

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic [15:0] limit_reg;
    parse_t      parse_reg;
    parse_t      parse_next;
    logic        out_valid_reg;
    logic [2:0]  verdict_reg;
    logic [3:0]  method_reg;
    logic [15:0] uri_offset_reg;
    logic [15:0] uri_length_reg;

    logic        advance;
    parse_t      step;
    logic        lf_done;
    logic [COUNT_BITS-1:0] pos;
    logic [3:0]  code;
    logic [2:0]  verdict;
    logic [EXT_W-1:0] total_ext;
    logic [EXT_W-1:0] uri_start_ext;
    logic [EXT_W-1:0] uri_len_ext;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        step    = parse_reg;
        pos     = parse_reg.byte_count;
        lf_done = 1'b0;
        if (!step.terminated) begin
            if (step.prev_cr) begin
                step.prev_cr = 1'b0;
                if (in_data_reg == hrv_pkg::CH_LF) begin
                    step    = line_end(step);
                    lf_done = 1'b1;
                end
                else begin
                    step = line_char(step, hrv_pkg::CH_CR, pos - COUNT_BITS'(1));
                end
            end
            if (!lf_done) begin
                priority if (in_data_reg == hrv_pkg::CH_NUL) begin
                    step.terminated = 1'b1;
                end
                else if (in_data_reg == hrv_pkg::CH_CR && !in_last_reg) begin
                    step.prev_cr = 1'b1;
                end
                else begin
                    // a CR on the last byte closes nothing and counts as content
                    step = line_char(step, in_data_reg, pos);
                end
            end
        end
        if (step.byte_count != '1) begin
            step.byte_count = step.byte_count + COUNT_BITS'(1);
        end

        code = hrv_pkg::M_UNKNOWN;
        for (int i = 7; i >= 0; i--) begin
            if (step.cand[i] && hrv_pkg::METH_LEN[i] == step.mpos) begin
                code = 4'(i + 1);
            end
        end

        total_ext     = EXT_W'(step.byte_count);
        uri_start_ext = EXT_W'(step.uri_start);
        uri_len_ext   = EXT_W'(step.uri_len);

        priority if (total_ext == EXT_W'(limit_reg)) begin
            verdict = hrv_pkg::V_TOO_LARGE;
        end
        else if (step.crlf_count != hrv_pkg::CRLF_SAT) begin
            verdict = hrv_pkg::V_BAD_REQUEST;
        end
        else if (step.token_index < hrv_pkg::TOK_VERSION) begin
            verdict = hrv_pkg::V_BAD_REQUEST;
        end
        else if (step.vphase != hrv_pkg::VP_MIN) begin
            verdict = hrv_pkg::V_BAD_REQUEST;
        end
        else if (!(step.vexact && step.vpos == hrv_pkg::VPOS_FULL)) begin
            verdict = hrv_pkg::V_BAD_VERSION;
        end
        else if (code == hrv_pkg::M_UNKNOWN) begin
            verdict = hrv_pkg::V_NOT_IMPLEMENTED;
        end
        else if (code != hrv_pkg::M_GET && code != hrv_pkg::M_HEAD) begin
            verdict = hrv_pkg::V_NOT_ALLOWED;
        end
        else if (!step.host_ok) begin
            verdict = hrv_pkg::V_BAD_REQUEST;
        end
        else begin
            verdict = hrv_pkg::V_ACCEPTED;
        end

        parse_next = in_last_reg ? clear_state() : step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            limit_reg     <= hrv_pkg::LIMIT_RESET;
            parse_reg     <= clear_state();
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                parse_reg <= parse_next;
            end
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            verdict_reg    <= verdict;
            method_reg     <= code;
            uri_offset_reg <= uri_start_ext[15:0];
            uri_length_reg <= uri_len_ext[15:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, uri_length_reg, uri_offset_reg, method_reg, verdict_reg};

endmodule

[dv/tb_http_request_validator.sv]
// Self-checking testbench for the HTTP request validator against a byte-level predictor.
`timescale 1ns / 1ps

module tb_http_request_validator;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        hrv_pkg::verdict_t verdict;
        hrv_pkg::method_t  method;
        logic [15:0]       uri_offset;
        logic [15:0]       uri_length;
    } verdict_rec_t;

    class verdict_scoreboard;
        verdict_rec_t pending_verdicts[$];
        int unsigned  errors;
        logic [15:0]  limit;

        logic [15:0]      nbytes;
        logic [1:0]       line_ends;
        bit               cr_held;
        logic [2:0]       token_no;
        bit               in_tok;
        logic [7:0]       cand;
        logic [3:0]       mpos;
        hrv_pkg::vphase_t vphase;
        logic [3:0]       vpos;
        bit               v_exact;
        logic [15:0]      uri_at;
        logic [15:0]      uri_n;
        logic [2:0]       host_pos;
        bit               host_here;
        bit               host_prev;
        bit               host_ok;
        bit               stopped;

        function new();
            errors = 0;
            limit = hrv_pkg::LIMIT_RESET;
            clear();
        endfunction

        function void clear();
            nbytes = '0;
            line_ends = '0;
            cr_held = 1'b0;
            token_no = '0;
            in_tok = 1'b0;
            cand = 8'hFF;
            mpos = '0;
            vphase = hrv_pkg::VP_LIT0;
            vpos = '0;
            v_exact = 1'b1;
            uri_at = '0;
            uri_n = '0;
            host_pos = '0;
            host_here = 1'b0;
            host_prev = 1'b0;
            host_ok = 1'b0;
            stopped = 1'b0;
        endfunction

        function void set_limit(logic [15:0] v);
            limit = v;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        function void method_byte(logic [7:0] c);
            for (int i = 0; i < 8; i++)
                if (cand[i] && (mpos >= hrv_pkg::METH_LEN[i] ||
                                hrv_pkg::METH_CHARS[i][mpos[2:0]] != c))
                    cand[i] = 1'b0;
            if (mpos != hrv_pkg::MPOS_SAT)
                mpos++;
        endfunction

        function void version_byte(logic [7:0] c);
            bit digit;
            digit = (c >= hrv_pkg::CH_ZERO) && (c <= hrv_pkg::CH_NINE);
            case (vphase)
                hrv_pkg::VP_LIT0, hrv_pkg::VP_LIT1, hrv_pkg::VP_LIT2, hrv_pkg::VP_LIT3:
                    vphase = (c == hrv_pkg::VER_LIT[vphase[2:0]]) ?
                             hrv_pkg::vphase_t'(vphase + 4'd1) : hrv_pkg::VP_FAIL;
                hrv_pkg::VP_SLASH:
                    vphase = (c == hrv_pkg::CH_SLASH) ? hrv_pkg::VP_MAJ0 : hrv_pkg::VP_FAIL;
                hrv_pkg::VP_MAJ0:
                    vphase = digit ? hrv_pkg::VP_MAJ : hrv_pkg::VP_FAIL;
                hrv_pkg::VP_MAJ:
                    vphase = digit ? hrv_pkg::VP_MAJ :
                             (c == hrv_pkg::CH_DOT) ? hrv_pkg::VP_MIN0 : hrv_pkg::VP_FAIL;
                hrv_pkg::VP_MIN0, hrv_pkg::VP_MIN:
                    vphase = digit ? hrv_pkg::VP_MIN : hrv_pkg::VP_FAIL;
                default:
                    vphase = hrv_pkg::VP_FAIL;
            endcase
            if (vpos >= hrv_pkg::VPOS_FULL || c != hrv_pkg::VER_LIT[vpos[2:0]])
                v_exact = 1'b0;
            if (vpos != hrv_pkg::VPOS_SAT)
                vpos++;
        endfunction

        function void line_byte(logic [7:0] c, logic [15:0] pos);
            if (c == hrv_pkg::HOST_LIT[host_pos]) begin
                host_pos++;
                if (host_pos > hrv_pkg::HOST_LAST) begin
                    host_here = 1'b1;
                    host_pos = '0;
                end
            end
            else
                host_pos = (c == hrv_pkg::CH_H) ? 3'd1 : 3'd0;

            if (line_ends != 0)
                return;
            if (c == hrv_pkg::CH_SP) begin
                in_tok = 1'b0;
                return;
            end
            if (!in_tok) begin
                in_tok = 1'b1;
                if (token_no < hrv_pkg::TOK_SAT)
                    token_no++;
                if (token_no == hrv_pkg::TOK_URI)
                    uri_at = pos;
            end
            if (token_no == hrv_pkg::TOK_METHOD)
                method_byte(c);
            else if (token_no == hrv_pkg::TOK_URI) begin
                if (uri_n != 16'hFFFF)
                    uri_n++;
            end
            else if (token_no == hrv_pkg::TOK_VERSION)
                version_byte(c);
        endfunction

        function void end_line();
            if (host_prev)
                host_ok = 1'b1;
            host_prev = (line_ends != 0) && host_here;
            host_here = 1'b0;
            host_pos = '0;
            if (line_ends != hrv_pkg::CRLF_SAT)
                line_ends++;
        endfunction

        function hrv_pkg::method_t method_now();
            for (int i = 0; i < 8; i++)
                if (cand[i] && hrv_pkg::METH_LEN[i] == mpos)
                    return hrv_pkg::method_t'(4'(i + 1));
            return hrv_pkg::M_UNKNOWN;
        endfunction

        function void parse_byte(logic [7:0] c, logic lst);
            logic [15:0]  pos;
            bit           done;
            verdict_rec_t r;
            pos = nbytes;
            if (!stopped) begin
                done = 1'b0;
                if (cr_held) begin
                    cr_held = 1'b0;
                    if (c == hrv_pkg::CH_LF) begin
                        end_line();
                        done = 1'b1;
                    end
                    else
                        line_byte(hrv_pkg::CH_CR, pos - 16'd1);
                end
                if (!done) begin
                    if (c == hrv_pkg::CH_NUL)
                        stopped = 1'b1;
                    else if (c == hrv_pkg::CH_CR)
                        cr_held = 1'b1;
                    else
                        line_byte(c, pos);
                end
            end
            if (nbytes != 16'hFFFF)
                nbytes++;
            if (!lst)
                return;

            if (!stopped && cr_held) begin
                cr_held = 1'b0;
                line_byte(hrv_pkg::CH_CR, pos);
            end
            r.method = method_now();
            r.uri_offset = uri_at;
            r.uri_length = uri_n;
            if (nbytes == limit)
                r.verdict = hrv_pkg::V_TOO_LARGE;
            else if (line_ends != hrv_pkg::CRLF_SAT)
                r.verdict = hrv_pkg::V_BAD_REQUEST;
            else if (token_no < hrv_pkg::TOK_VERSION)
                r.verdict = hrv_pkg::V_BAD_REQUEST;
            else if (vphase != hrv_pkg::VP_MIN)
                r.verdict = hrv_pkg::V_BAD_REQUEST;
            else if (!(v_exact && vpos == hrv_pkg::VPOS_FULL))
                r.verdict = hrv_pkg::V_BAD_VERSION;
            else if (r.method == hrv_pkg::M_UNKNOWN)
                r.verdict = hrv_pkg::V_NOT_IMPLEMENTED;
            else if (r.method > hrv_pkg::M_HEAD)
                r.verdict = hrv_pkg::V_NOT_ALLOWED;
            else if (!host_ok)
                r.verdict = hrv_pkg::V_BAD_REQUEST;
            else
                r.verdict = hrv_pkg::V_ACCEPTED;
            pending_verdicts.push_back(r);
            clear();
        endfunction

        function void check_verdict(logic [39:0] d);
            verdict_rec_t e;
            if (pending_verdicts.size() == 0) begin
                $error("verdict item with none pending: %h", d);
                errors++;
                return;
            end
            e = pending_verdicts.pop_front();
            if (d[2:0] !== e.verdict) begin
                $error("verdict: expected %0d, actual %0d", e.verdict, d[2:0]);
                errors++;
            end
            if (d[6:3] !== e.method) begin
                $error("method_code: expected %0d, actual %0d", e.method, d[6:3]);
                errors++;
            end
            if (d[22:7] !== e.uri_offset) begin
                $error("uri_offset: expected %0d, actual %0d", e.uri_offset, d[22:7]);
                errors++;
            end
            if (d[38:23] !== e.uri_length) begin
                $error("uri_length: expected %0d, actual %0d", e.uri_length, d[38:23]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    verdict_scoreboard sb;
    logic [7:0]  req_bytes[$];
    int unsigned bytes_sent = 0;
    int unsigned n_req = 0;
    int unsigned quiet_cycles = 0;
    bit          steady = 1'b0;
    int          req_len;

    string caps_set  = "ABCDEGHINOPRSTU";
    string uri_set   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789/._-?=&%~:";
    string value_set = "Hostabcxyz019 :-/.H";
    string noise_set = "HTTP/1.GE Host:";

    http_request_validator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.parse_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_verdict(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 18);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("http_request_validator verification failed");
            $finish;
        end
    end

    function automatic void add_byte(logic [7:0] b);
        req_bytes.push_back(b);
    endfunction

    // '|' ends a line, '%' is a bare CR, '#' is a NUL
    function automatic void add(string s);
        for (int i = 0; i < s.len(); i++)
            case (s[i])
                "|":
                begin
                    req_bytes.push_back(hrv_pkg::CH_CR);
                    req_bytes.push_back(hrv_pkg::CH_LF);
                end
                "%": req_bytes.push_back(hrv_pkg::CH_CR);
                "#": req_bytes.push_back(hrv_pkg::CH_NUL);
                default: req_bytes.push_back(s[i]);
            endcase
    endfunction

    function automatic void add_rand(int n, string set);
        repeat (n) req_bytes.push_back(set[$urandom_range(set.len() - 1)]);
    endfunction

    function automatic void add_method(int m);
        for (int j = 0; j < hrv_pkg::METH_LEN[m]; j++)
            req_bytes.push_back(hrv_pkg::METH_CHARS[m][j]);
    endfunction

    function automatic void add_spaces();
        int n;
        n = ($urandom_range(4) == 0) ? $urandom_range(3, 2) : 1;
        repeat (n) req_bytes.push_back(hrv_pkg::CH_SP);
    endfunction

    function automatic string version_form(int k);
        case (k)
            0:  return "HTTP/1.0";
            1:  return "HTTP/2.0";
            2:  return "HTTP/11.1";
            3:  return "HTTP/1.10";
            4:  return "HTTP/1.";
            5:  return "HTTP/.1";
            6:  return "HTTP/1";
            7:  return "HTTP1.1";
            8:  return "HTTPS/1.1";
            9:  return "http/1.1";
            10: return "HTTP/1.1x";
            11: return "HTTP/01.1";
            12: return "HTTP/1.1.1";
            13: return "HTTX/1.1";
            default: return "HTTP/9.123456";
        endcase
    endfunction

    function automatic string host_form();
        case ($urandom_range(9))
            0: return "host: ";
            1: return "HHost: ";
            2: return "Hos: ";
            3: return "X-Host:";
            default: return "Host: ";
        endcase
    endfunction

    function automatic void random_request();
        int k;
        int start;
        int n;
        int host_at;
        k = $urandom_range(99);
        if (k < 12) begin
            repeat ($urandom_range(30, 1))
                case ($urandom_range(3))
                    0: add_byte(8'($urandom_range(255)));
                    1: add_byte(hrv_pkg::CH_CR);
                    2: add_byte(hrv_pkg::CH_LF);
                    default: add_rand(1, noise_set);
                endcase
            return;
        end

        if ($urandom_range(9) == 0)
            add(" ");
        k = $urandom_range(99);
        if (k < 45)
            add_method($urandom_range(1));
        else if (k < 70)
            add_method($urandom_range(7));
        else if (k < 85) begin
            start = req_bytes.size();
            add_method($urandom_range(7));
            case ($urandom_range(2))
                0: void'(req_bytes.pop_back());
                1: add_rand(1, caps_set);
                default: req_bytes[start + $urandom_range(req_bytes.size() - start - 1)] =
                             caps_set[$urandom_range(caps_set.len() - 1)];
            endcase
        end
        else if (k < 95)
            add_rand($urandom_range(18, 1), caps_set);
        add_spaces();

        if ($urandom_range(19) != 0) begin
            add("/");
            add_rand($urandom_range(10), uri_set);
            if ($urandom_range(29) == 0)
                add_byte(hrv_pkg::CH_CR);
        end
        add_spaces();

        k = $urandom_range(99);
        if (k < 75)
            add("HTTP/1.1");
        else if (k < 95)
            add(version_form($urandom_range(14)));
        if ($urandom_range(11) == 0) begin
            add(" ");
            add_rand($urandom_range(6, 1), uri_set);
        end
        if ($urandom_range(19) != 0)
            add("|");
        else
            add_byte(hrv_pkg::CH_LF);

        n = $urandom_range(3);
        host_at = ($urandom_range(9) < 8) ? $urandom_range(n) : -1;
        for (int i = 0; i <= n; i++) begin
            if (i == host_at) begin
                add(host_form());
                add_rand($urandom_range(8), value_set);
                add("|");
            end
            if (i < n) begin
                add_rand($urandom_range(6, 1), caps_set);
                add(": ");
                add_rand($urandom_range(8), value_set);
                if ($urandom_range(19) != 0)
                    add("|");
                else
                    add_byte(hrv_pkg::CH_LF);
            end
        end

        k = $urandom_range(99);
        if (k < 85)
            add("|");
        else if (k >= 92)
            add("%");
        if ($urandom_range(7) == 0)
            add_rand($urandom_range(8, 1), value_set);
        if ($urandom_range(24) == 0)
            req_bytes[$urandom_range(req_bytes.size() - 1)] = hrv_pkg::CH_NUL;
    endfunction

    task automatic push_byte(logic [7:0] b, logic lst);
        while (!steady && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_request();
        for (int i = 0; i < req_bytes.size(); i++)
            push_byte(req_bytes[i], i == req_bytes.size() - 1);
        bytes_sent += req_bytes.size();
        req_bytes.delete();
    endtask

    task automatic send_text(string s);
        add(s);
        send_request();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(logic [15:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_limit(v);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("GET /index.html HTTP/1.1|Host: example.com||");
        send_text("HEAD   /a/b?c=d    HTTP/1.1|Accept: */*|Host: h||");
        for (int m = 2; m < 8; m++) begin
            add_method(m);
            send_text(" /x HTTP/1.1|Host: h||");
        end
        send_text("BREW /pot HTTP/1.1|Host: h||");
        send_text("GETS / HTTP/1.1|Host: h||");
        send_text("GET / HTTP/1.0|Host: h||");
        send_text("GET / HTTP/10.25|Host: h||");
        send_text("GET / HTTP/1.|Host: h||");
        send_text("GET / HTTP/1.1234|Host: h||");
        send_text("GET /|Host: h||");
        send_text("GET|Host: h||");
        send_text("  GET  /  HTTP/1.1  extra tokens here|Host: h||");
        send_text("GET / HTTP/1.1|Host: h|");
        send_text("GET /Host: HTTP/1.1|X: y||");
        send_text("GET / HTTP/1.1|X: y|Host: h|");
        send_text("GET / HTTP/1.1|A: b||Host: z");
        send_text("GET /a%b HTTP/1.1|X-Host: h||");
        send_text("GET / HTTP/1.1|Host: h||#trailing");
        send_text("GET /a#b HTTP/1.1|Host: h||");
        send_text("ABCDEFGHIJKLMNOPQRST / HTTP/1.1|Host: h||");
        send_text("GET / HTTP/1.1|Host: h||%");
        add_byte(8'hFF);
        send_request();

        add("GET / HTTP/1.1|Host: h||");
        set_limit(16'(req_bytes.size()));
        send_request();
        send_text("GET / HTTP/1.1|Host: h||x");
        set_limit(16'd1);
        send_text("G");
        set_limit(16'd0);
        add_byte(hrv_pkg::CH_NUL);
        send_request();

        while (bytes_sent < 1800) begin
            random_request();
            if (n_req % 6 == 5) begin
                req_len = req_bytes.size();
                case ($urandom_range(6))
                    0: set_limit(16'd1);
                    1: set_limit(16'd0);
                    2: set_limit(16'hFFFF);
                    3: set_limit(hrv_pkg::LIMIT_RESET);
                    4, 5: set_limit(16'(req_len));
                    default: set_limit(16'($urandom_range(65535, 1)));
                endcase
            end
            steady = (n_req >= 6 && n_req < 14);
            send_request();
            n_req++;
        end
        steady = 1'b0;

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("http_request_validator verification clean");
        else
            $display("http_request_validator verification failed");
        $finish;
    end

endmodule
